/* sv/prfi_pkg.sv */
`default_nettype none

package prfi_pkg;

    // field widths fixed by the request and response formats
    localparam int PAGE_W      = 48;
    localparam int CORE_W      = 4;
    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int ACT_CNT_W   = 4;
    localparam int MASK_W      = 8;

    // most pages one drain may return
    localparam int MAX_RESULTS = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_MASK    = 2'd1;

    localparam logic [ACT_CNT_W-1:0] ACTIVE_COUNT_RST = 4'd8;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_CORE = 2'd1,
        STATUS_INACTIVE = 2'd2,
        STATUS_FULL     = 2'd3
    } t_status;

    typedef enum logic {
        FUNC_ENQUEUE = 1'b0,
        FUNC_DRAIN   = 1'b1
    } t_func;

    typedef enum logic {
        ALU_INC  = 1'b0,
        ALU_DIST = 1'b1
    } t_alu_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COUNT,
        ST_EXEC,
        ST_READ,
        ST_RESP,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              func;
        logic [CORE_W-1:0] core_id;
        logic [PAGE_W-1:0] free_page;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic              page_valid;
        logic [PAGE_W-1:0] out_page;
        logic              last;
        logic              has_space;
        logic [CNT_W-1:0]  enqueue_total;
        logic [CNT_W-1:0]  enqueue_fail_total;
        logic [CNT_W-1:0]  drain_batch_total;
        logic [CNT_W-1:0]  drain_page_total;
    } t_rsp;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic req_fire;
        logic rsp_fire;
        logic batch_go;
        logic more_pages;
    } t_seq_flags;

    // step strobes from the sequencer
    typedef struct packed {
        logic req_ready;
        logic rsp_valid;
        logic load;
        logic count;
        logic exec;
        logic read;
        logic resp;
    } t_seq_ctl;

endpackage

`default_nettype wire

/* sv/prfi_ptr_alu.sv */
`default_nettype none

module prfi_ptr_alu #(
    parameter int INBOX_DEPTH = 64,
    parameter int PW          = 6
) (
    input  var prfi_pkg::t_alu_op i_op,
    input  var logic [PW-1:0]     i_a,
    input  var logic [PW-1:0]     i_b,
    output logic [PW-1:0]         o_y
);
    import prfi_pkg::*;

    logic [PW:0] wrap_sum;

    // distance around the ring when a is behind b
    assign wrap_sum = (PW+1)'(i_a) + (PW+1)'(INBOX_DEPTH) - (PW+1)'(i_b);

    // modular increment or modular distance a - b
    always_comb begin
        case (i_op)
            ALU_INC: begin
                o_y = (i_a == PW'(INBOX_DEPTH - 1)) ? '0 : i_a + 1'b1;
            end
            ALU_DIST: begin
                o_y = (i_a >= i_b) ? i_a - i_b : wrap_sum[PW-1:0];
            end
            default: begin
                o_y = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/prfi_page_ram.sv */
`default_nettype none

module prfi_page_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  var logic                        i_clk,
    input  var logic                        i_we,
    input  var logic [AW-1:0]               i_waddr,
    input  var logic [prfi_pkg::PAGE_W-1:0] i_wdata,
    input  var logic                        i_re,
    input  var logic [AW-1:0]               i_raddr,
    output logic [prfi_pkg::PAGE_W-1:0]     o_rdata
);
    import prfi_pkg::*;

    logic [PAGE_W-1:0] r_mem [DEPTH];

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // one registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/prfi_seq.sv */
`default_nettype none

module prfi_seq (
    input  var logic                 i_clk,
    input  var logic                 i_rst_n,
    input  var prfi_pkg::t_seq_flags i_flags,
    output prfi_pkg::t_seq_ctl       o_ctl
);
    import prfi_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_flags.req_fire) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD:  n_state = ST_COUNT;
            ST_COUNT: n_state = ST_EXEC;
            ST_EXEC: begin
                n_state = i_flags.batch_go ? ST_READ : ST_RESP;
            end
            ST_READ:  n_state = ST_RESP;
            ST_RESP:  n_state = ST_OUT;
            ST_OUT: begin
                if (i_flags.rsp_fire) begin
                    n_state = i_flags.more_pages ? ST_READ : ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // step strobes
    always_comb begin
        o_ctl = '0;
        case (r_state)
            ST_IDLE:  o_ctl.req_ready = 1'b1;
            ST_LOAD:  o_ctl.load      = 1'b1;
            ST_COUNT: o_ctl.count     = 1'b1;
            ST_EXEC:  o_ctl.exec      = 1'b1;
            ST_READ:  o_ctl.read      = 1'b1;
            ST_RESP:  o_ctl.resp      = 1'b1;
            ST_OUT:   o_ctl.rsp_valid = 1'b1;
            default:  o_ctl = '0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/per_core_remote_free_inbox.sv */
`default_nettype none

// Per-core inbox of page addresses, one ring of INBOX_DEPTH slots per core with one slot
// always left free. An enqueue request stores a page in the addressed core's ring, or
// reports an invalid core, an inactive core or a full ring; a drain request pops up to
// min(BATCH_MAX, 16) pages and returns one response per page, the final one marked last,
// or a single response without a page when it finds none. Every response for a valid core
// carries the core's four wrapping counters as they stand after the whole request; for an
// invalid core they read zero. One request is handled at a time: the sequencer steps
// through load, count and execute, then for each drained page a read, and builds each
// response in a register that it holds until taken, so responses may stall; it takes
// the next request once the last response is accepted. It steps one shared ring-pointer
// unit, and the page memory has a single registered read port. The page memory is not
// cleared at reset; configuration writes are always taken.
module per_core_remote_free_inbox #(
    parameter int NUM_CORES   = 8,
    parameter int INBOX_DEPTH = 64,
    parameter int BATCH_MAX   = 16
) (
    input  var logic                           i_clk,
    input  var logic                           i_rst_n,
    input  var logic                           i_req_valid,
    output logic                               o_req_ready,
    input  var prfi_pkg::t_req                 i_req,
    output logic                               o_rsp_valid,
    input  var logic                           i_rsp_ready,
    output prfi_pkg::t_rsp                     o_rsp,
    input  var logic                           i_cfg_valid,
    output logic                               o_cfg_ready,
    input  var logic [prfi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  var logic [prfi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import prfi_pkg::*;

    localparam int LIMIT   = (BATCH_MAX < MAX_RESULTS) ? BATCH_MAX : MAX_RESULTS;
    localparam int NW      = $clog2(LIMIT + 1);
    localparam int PW      = $clog2(INBOX_DEPTH);
    localparam int CW      = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int MDEPTH  = NUM_CORES * INBOX_DEPTH;
    localparam int AW      = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

    // configuration
    logic [ACT_CNT_W-1:0] r_active_count;
    logic [MASK_W-1:0]    r_core_mask;

    // per-core ring state
    logic [PW-1:0]    r_wp          [NUM_CORES];
    logic [PW-1:0]    r_rp          [NUM_CORES];
    logic [CNT_W-1:0] r_enq_cnt     [NUM_CORES];
    logic [CNT_W-1:0] r_fail_cnt    [NUM_CORES];
    logic [CNT_W-1:0] r_batch_cnt   [NUM_CORES];
    logic [CNT_W-1:0] r_drained_cnt [NUM_CORES];

    // request in progress
    t_req          r_req;
    logic          r_core_ok;
    logic          r_core_act;
    logic [PW-1:0] r_wp_c;
    logic [PW-1:0] r_rp_c;
    logic [PW-1:0] r_cnt;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_n;
    logic [NW-1:0] r_i;
    logic          r_batch;
    t_status       r_status;
    logic          r_has_space;
    t_rsp          r_out;

    logic [CW-1:0]     core_idx;
    logic              core_ok;
    logic              core_act;
    logic              is_drain;
    logic              ring_full;
    logic [NW-1:0]     batch_n;
    t_alu_op           alu_op;
    logic [PW-1:0]     alu_a;
    logic [PW-1:0]     alu_y;
    logic              ram_we;
    logic              ram_re;
    logic [AW-1:0]     ram_base;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [PAGE_W-1:0] ram_q;
    t_seq_flags        flags;
    t_seq_ctl          ctl;

    assign core_idx  = r_req.core_id[CW-1:0];
    assign core_ok   = (r_req.core_id < r_active_count)
                    && ({1'b0, r_req.core_id} < 5'(NUM_CORES));
    assign core_act  = !r_req.core_id[3] && r_core_mask[r_req.core_id[2:0]];
    assign is_drain  = (r_req.func == FUNC_DRAIN);
    assign ring_full = (32'(r_cnt) == 32'(INBOX_DEPTH - 1));
    assign batch_n   = (32'(r_cnt) < 32'(LIMIT)) ? NW'(r_cnt) : NW'(LIMIT);

    // sequencer
    always_comb begin
        flags.req_fire   = i_req_valid && o_req_ready;
        flags.rsp_fire   = o_rsp_valid && i_rsp_ready;
        flags.batch_go   = r_core_ok && r_core_act && is_drain && (r_cnt != '0);
        flags.more_pages = r_batch && (r_i != r_n);
    end

    prfi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_ctl   (ctl)
    );

    // shared ring-pointer unit
    always_comb begin
        alu_op = ctl.count ? ALU_DIST : ALU_INC;
        alu_a  = ctl.read ? r_rd : r_wp_c;
    end

    prfi_ptr_alu #(
        .INBOX_DEPTH (INBOX_DEPTH),
        .PW          (PW)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (r_rp_c),
        .o_y  (alu_y)
    );

    // page memory, one ring per core
    assign ram_base  = AW'(core_idx) * AW'(INBOX_DEPTH);
    assign ram_waddr = ram_base + AW'(r_wp_c);
    assign ram_raddr = ram_base + AW'(r_rd);
    assign ram_we    = ctl.exec && r_core_ok && r_core_act && !is_drain && !ring_full;
    assign ram_re    = ctl.read;

    prfi_page_ram #(
        .DEPTH (MDEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_req.free_page),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= ACTIVE_COUNT_RST;
            r_core_mask    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ACTIVE_COUNT: r_active_count <= i_cfg_data[ACT_CNT_W-1:0];
                CFG_CORE_MASK:    r_core_mask    <= i_cfg_data[MASK_W-1:0];
                default:          ;
            endcase
        end
    end

    // ring pointers and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CORES; c++) begin
                r_wp[c]          <= '0;
                r_rp[c]          <= '0;
                r_enq_cnt[c]     <= '0;
                r_fail_cnt[c]    <= '0;
                r_batch_cnt[c]   <= '0;
                r_drained_cnt[c] <= '0;
            end
        end else begin
            if (ctl.exec && r_core_ok && r_core_act) begin
                if (!is_drain && ring_full) begin
                    r_fail_cnt[core_idx] <= r_fail_cnt[core_idx] + 1'b1;
                end else if (!is_drain) begin
                    r_wp[core_idx]      <= alu_y;
                    r_enq_cnt[core_idx] <= r_enq_cnt[core_idx] + 1'b1;
                end else if (r_cnt != '0) begin
                    r_batch_cnt[core_idx]   <= r_batch_cnt[core_idx] + 1'b1;
                    r_drained_cnt[core_idx] <= r_drained_cnt[core_idx] + CNT_W'(batch_n);
                end
            end
            if (ctl.read) begin
                r_rp[core_idx] <= alu_y;
            end
        end
    end

    // request capture and per-step working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batch <= 1'b0;
            r_n     <= '0;
            r_i     <= '0;
        end else begin
            if (flags.req_fire) begin
                r_req   <= i_req;
                r_batch <= 1'b0;
            end
            if (ctl.load) begin
                r_core_ok  <= core_ok;
                r_core_act <= core_act;
                r_wp_c     <= r_wp[core_idx];
                r_rp_c     <= r_rp[core_idx];
            end
            if (ctl.count) begin
                r_cnt <= alu_y;
            end
            if (ctl.exec) begin
                r_batch <= flags.batch_go;
                r_n     <= batch_n;
                r_i     <= '0;
                r_rd    <= r_rp_c;
                if (!r_core_ok) begin
                    r_status    <= STATUS_BAD_CORE;
                    r_has_space <= 1'b0;
                end else if (!r_core_act) begin
                    r_status    <= STATUS_INACTIVE;
                    r_has_space <= (32'(r_cnt) < 32'(INBOX_DEPTH - 1));
                end else if (!is_drain && ring_full) begin
                    r_status    <= STATUS_FULL;
                    r_has_space <= 1'b0;
                end else if (!is_drain) begin
                    r_status    <= STATUS_OK;
                    r_has_space <= (32'(r_cnt) + 32'd1 < 32'(INBOX_DEPTH - 1));
                end else begin
                    r_status    <= STATUS_OK;
                    r_has_space <= (32'(r_cnt) - 32'(batch_n) < 32'(INBOX_DEPTH - 1));
                end
            end
            if (ctl.read) begin
                r_rd <= alu_y;
                r_i  <= r_i + 1'b1;
            end
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (ctl.resp) begin
            r_out.status     <= r_status;
            r_out.page_valid <= r_batch;
            r_out.out_page   <= r_batch ? ram_q : '0;
            r_out.last       <= !(r_batch && (r_i != r_n));
            r_out.has_space  <= r_has_space;
            if (r_core_ok) begin
                r_out.enqueue_total      <= r_enq_cnt[core_idx];
                r_out.enqueue_fail_total <= r_fail_cnt[core_idx];
                r_out.drain_batch_total  <= r_batch_cnt[core_idx];
                r_out.drain_page_total   <= r_drained_cnt[core_idx];
            end else begin
                r_out.enqueue_total      <= '0;
                r_out.enqueue_fail_total <= '0;
                r_out.drain_batch_total  <= '0;
                r_out.drain_page_total   <= '0;
            end
        end
    end

    assign o_req_ready = ctl.req_ready;
    assign o_rsp_valid = ctl.rsp_valid;
    assign o_rsp       = r_out;
    assign o_cfg_ready = 1'b1;

    // a drain batch stays within the batch limit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_batch |-> (r_n != '0) && (32'(r_n) <= 32'(LIMIT)) && (r_i <= r_n))
        else $error("drain batch count out of range");

    // ring occupancy never reaches the full depth
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.exec |-> (32'(r_cnt) < 32'(INBOX_DEPTH)))
        else $error("ring occupancy beyond depth");

    // pages are stored only for a valid, active core
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_core_ok && r_core_act && !is_drain))
        else $error("page write for rejected request");

    // the last response frees the block for a new request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_ready && o_rsp.last) |=> o_req_ready)
        else $error("block not idle after last response");

    // responses other than pages always close the request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.page_valid) |-> o_rsp.last)
        else $error("non-page response not marked last");

endmodule

`default_nettype wire

/* tb/tb_per_core_remote_free_inbox.sv */
`default_nettype none

module tb_per_core_remote_free_inbox;
    timeunit 1ns;
    timeprecision 1ps;

    import prfi_pkg::*;

    localparam int N_CORES   = 8;
    localparam int N_DEPTH   = 64;
    localparam int BATCH_LIM = 16;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // directed request with an optional hand-written response
    typedef struct packed {
        t_func             func;
        logic [CORE_W-1:0] core;
        logic [PAGE_W-1:0] page;
        logic              typed;
        t_status           want_status;
        logic              want_space;
    } t_dir_row;

    // typed rows only hit cores whose counters are still zero
    localparam int DIR_ROWS = 20;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // reset settings: no core active yet
        '{FUNC_ENQUEUE, 4'd0,  48'h0000_0000_0000, 1'b1, STATUS_INACTIVE, 1'b1},
        '{FUNC_DRAIN,   4'd7,  48'hFFFF_FFFF_FFFF, 1'b1, STATUS_INACTIVE, 1'b1},
        '{FUNC_ENQUEUE, 4'd8,  48'hFFFF_FFFF_FFFF, 1'b1, STATUS_BAD_CORE, 1'b0},
        '{FUNC_DRAIN,   4'd15, 48'h0000_0000_0000, 1'b1, STATUS_BAD_CORE, 1'b0},
        // cores 0..6 active
        '{FUNC_DRAIN,   4'd0,  48'h0000_0000_0000, 1'b1, STATUS_OK,       1'b1},
        '{FUNC_ENQUEUE, 4'd0,  48'hFFFF_FFFF_FFFF, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_ENQUEUE, 4'd0,  48'h0000_0000_0000, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_ENQUEUE, 4'd0,  48'h5555_5555_5555, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_ENQUEUE, 4'd0,  48'hAAAA_AAAA_AAAA, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_DRAIN,   4'd0,  48'h0000_0000_0000, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_DRAIN,   4'd0,  48'h1234_5678_9ABC, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_ENQUEUE, 4'd7,  48'h0123_4567_89AB, 1'b1, STATUS_INACTIVE, 1'b1},
        '{FUNC_DRAIN,   4'd7,  48'h0000_0000_0000, 1'b1, STATUS_INACTIVE, 1'b1},
        '{FUNC_ENQUEUE, 4'd6,  48'h8000_0000_0001, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_ENQUEUE, 4'd5,  48'h7FFF_FFFF_FFFE, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_ENQUEUE, 4'd6,  48'hFEDC_BA98_7654, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_DRAIN,   4'd6,  48'h0000_0000_0000, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_DRAIN,   4'd5,  48'h0000_0000_0000, 1'b0, STATUS_OK,       1'b0},
        '{FUNC_ENQUEUE, 4'd9,  48'h0F0F_0F0F_0F0F, 1'b1, STATUS_BAD_CORE, 1'b0},
        '{FUNC_DRAIN,   4'd12, 48'h0000_0000_0000, 1'b1, STATUS_BAD_CORE, 1'b0}
    };

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_req_valid = 1'b0;
    logic                   o_req_ready;
    t_req                   i_req       = '0;
    logic                   o_rsp_valid;
    logic                   i_rsp_ready = 1'b0;
    t_rsp                   o_rsp;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    // shadow of the inboxes and registers
    logic [ACT_CNT_W-1:0] cur_count = ACTIVE_COUNT_RST;
    logic [MASK_W-1:0]    cur_mask  = '0;
    int                   wr_ptr [N_CORES] = '{default: 0};
    int                   rd_ptr [N_CORES] = '{default: 0};
    logic [PAGE_W-1:0]    page_mem [N_CORES*N_DEPTH] = '{default: '0};
    logic [CNT_W-1:0]     enq_cnt [N_CORES] = '{default: '0};
    logic [CNT_W-1:0]     fail_cnt [N_CORES] = '{default: '0};
    logic [CNT_W-1:0]     batch_cnt [N_CORES] = '{default: '0};
    logic [CNT_W-1:0]     drained_cnt [N_CORES] = '{default: '0};

    t_rsp awaited_rsp [$];
    t_rsp want_rsp;

    bit no_idle = 1'b0;
    int n_errors   = 0;
    int n_reqs     = 0;
    int n_rsps     = 0;
    int n_pages    = 0;
    int n_full     = 0;
    int n_settings = 0;

    per_core_remote_free_inbox #(
        .NUM_CORES  (N_CORES),
        .INBOX_DEPTH(N_DEPTH),
        .BATCH_MAX  (BATCH_LIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // response stalls
    always @(negedge i_clk) begin
        i_rsp_ready <= no_idle || ($urandom_range(99) >= 37);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        n_errors++;
        $display("mismatch on %s at response %0d: got %0h, expected %0h",
                 what, n_rsps, got, exp_val);
    endtask

    // response view of one core after the whole request
    function automatic t_rsp core_view(input int c, input t_status st, input logic pv,
                                       input logic [PAGE_W-1:0] pg, input logic lst);
        t_rsp r;
        r = '0;
        r.status             = st;
        r.page_valid         = pv;
        r.out_page           = pg;
        r.last               = lst;
        r.has_space          = ((wr_ptr[c] + 1) % N_DEPTH) != rd_ptr[c];
        r.enqueue_total      = enq_cnt[c];
        r.enqueue_fail_total = fail_cnt[c];
        r.drain_batch_total  = batch_cnt[c];
        r.drain_page_total   = drained_cnt[c];
        return r;
    endfunction

    // apply one request to the shadow inboxes and queue its responses
    function automatic void predict_inbox_rsp(input t_req r);
        int                c;
        int                n;
        int                nx;
        logic [PAGE_W-1:0] popped [BATCH_LIM];
        t_rsp              bad;
        c   = int'(r.core_id);
        n   = 0;
        bad = '0;
        if (c >= int'(cur_count) || c >= N_CORES) begin
            bad.status = STATUS_BAD_CORE;
            bad.last   = 1'b1;
            awaited_rsp.push_back(bad);
            return;
        end
        if (!cur_mask[c]) begin
            awaited_rsp.push_back(core_view(c, STATUS_INACTIVE, 1'b0, '0, 1'b1));
            return;
        end
        if (r.func == FUNC_ENQUEUE) begin
            nx = (wr_ptr[c] + 1) % N_DEPTH;
            if (nx == rd_ptr[c]) begin
                fail_cnt[c]++;
                n_full++;
                awaited_rsp.push_back(core_view(c, STATUS_FULL, 1'b0, '0, 1'b1));
                return;
            end
            page_mem[c*N_DEPTH + wr_ptr[c]] = r.free_page;
            wr_ptr[c] = nx;
            enq_cnt[c]++;
            awaited_rsp.push_back(core_view(c, STATUS_OK, 1'b0, '0, 1'b1));
            return;
        end
        // drain up to one batch
        while (wr_ptr[c] != rd_ptr[c] && n < BATCH_LIM) begin
            popped[n] = page_mem[c*N_DEPTH + rd_ptr[c]];
            rd_ptr[c] = (rd_ptr[c] + 1) % N_DEPTH;
            n++;
        end
        if (n == 0) begin
            awaited_rsp.push_back(core_view(c, STATUS_OK, 1'b0, '0, 1'b1));
            return;
        end
        batch_cnt[c]++;
        drained_cnt[c] += CNT_W'(n);
        n_pages += n;
        for (int i = 0; i < n; i++) begin
            awaited_rsp.push_back(core_view(c, STATUS_OK, 1'b1, popped[i], i == n - 1));
        end
    endfunction

    // response checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            n_rsps++;
            if (awaited_rsp.size() == 0) begin
                report_mismatch("response with nothing outstanding",
                                64'(o_rsp.out_page), '0);
            end else begin
                want_rsp = awaited_rsp.pop_front();
                if (o_rsp.status !== want_rsp.status)
                    report_mismatch("status", 64'(o_rsp.status), 64'(want_rsp.status));
                if (o_rsp.page_valid !== want_rsp.page_valid)
                    report_mismatch("page_valid", 64'(o_rsp.page_valid),
                                    64'(want_rsp.page_valid));
                if (o_rsp.out_page !== want_rsp.out_page)
                    report_mismatch("out_page", 64'(o_rsp.out_page),
                                    64'(want_rsp.out_page));
                if (o_rsp.last !== want_rsp.last)
                    report_mismatch("last", 64'(o_rsp.last), 64'(want_rsp.last));
                if (o_rsp.has_space !== want_rsp.has_space)
                    report_mismatch("has_space", 64'(o_rsp.has_space),
                                    64'(want_rsp.has_space));
                if (o_rsp.enqueue_total !== want_rsp.enqueue_total)
                    report_mismatch("enqueue_total", 64'(o_rsp.enqueue_total),
                                    64'(want_rsp.enqueue_total));
                if (o_rsp.enqueue_fail_total !== want_rsp.enqueue_fail_total)
                    report_mismatch("enqueue_fail_total", 64'(o_rsp.enqueue_fail_total),
                                    64'(want_rsp.enqueue_fail_total));
                if (o_rsp.drain_batch_total !== want_rsp.drain_batch_total)
                    report_mismatch("drain_batch_total", 64'(o_rsp.drain_batch_total),
                                    64'(want_rsp.drain_batch_total));
                if (o_rsp.drain_page_total !== want_rsp.drain_page_total)
                    report_mismatch("drain_page_total", 64'(o_rsp.drain_page_total),
                                    64'(want_rsp.drain_page_total));
            end
        end
    end

    // one request; valid stays up after acceptance until the next negedge
    task automatic send_req(input t_req r, input bit typed = 1'b0, input t_rsp want = '0);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 37) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        n_reqs++;
        // typed rows never change the inboxes
        if (typed)
            awaited_rsp.push_back(want);
        else
            predict_inbox_rsp(r);
    endtask

    task automatic release_req();
        @(negedge i_clk);
        i_req_valid <= 1'b0;
    endtask

    task automatic wait_all_rsp();
        while (awaited_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ACTIVE_COUNT: cur_count = data[ACT_CNT_W-1:0];
            CFG_CORE_MASK:    cur_mask  = data[MASK_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_req rand_req(input logic f, input int core);
        t_req        r;
        logic [63:0] bits;
        bits        = {$urandom(), $urandom()};
        r.func      = f;
        r.core_id   = CORE_W'(core);
        r.free_page = bits[PAGE_W-1:0];
        return r;
    endfunction

    task automatic run_table(input int lo, input int hi);
        t_req r;
        t_rsp want;
        for (int i = lo; i <= hi; i++) begin
            r.func           = DIR_TABLE[i].func;
            r.core_id        = DIR_TABLE[i].core;
            r.free_page      = DIR_TABLE[i].page;
            want             = '0;
            want.status      = DIR_TABLE[i].want_status;
            want.last        = 1'b1;
            want.has_space   = DIR_TABLE[i].want_space;
            send_req(r, DIR_TABLE[i].typed, want);
        end
    endtask

    // mostly valid cores, bursts of enqueues followed by a drain
    task automatic random_phase(input int n_items);
        int sent;
        int pick;
        int len;
        int core;
        bit held;
        sent = 0;
        held = 1'b0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            core = $urandom_range(N_CORES - 1);
            if (pick < 10) begin
                send_req(rand_req(1'($urandom_range(1)), $urandom_range(15)));
                sent++;
            end else if (pick < 30) begin
                len = $urandom_range(2, 12);
                repeat (len) send_req(rand_req(FUNC_ENQUEUE, core));
                send_req(rand_req(FUNC_DRAIN, core));
                sent += len + 1;
            end else if (pick < 65) begin
                send_req(rand_req(FUNC_ENQUEUE, core));
                sent++;
            end else begin
                send_req(rand_req(FUNC_DRAIN, core));
                sent++;
            end
            // hold the sender until the block has answered everything
            if (!held && sent >= n_items / 2) begin
                release_req();
                wait_all_rsp();
                held = 1'b1;
            end
        end
    endtask

    task automatic run_setting(input logic [CFG_DATA_W-1:0] count_data,
                               input logic [CFG_DATA_W-1:0] mask, input int n_items);
        release_req();
        wait_all_rsp();
        write_reg(CFG_ACTIVE_COUNT, count_data);
        write_reg(CFG_CORE_MASK, mask);
        n_settings++;
        random_phase(n_items);
    endtask

    // fill one inbox past full, then drain it to empty, no idling on either side
    task automatic overfill_inbox(input int core);
        no_idle = 1'b1;
        repeat (N_DEPTH + 2) send_req(rand_req(FUNC_ENQUEUE, core));
        repeat (N_DEPTH / BATCH_LIM + 1) send_req(rand_req(FUNC_DRAIN, core));
        no_idle = 1'b0;
    endtask

    // main sequence
    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_table(0, 3);
        release_req();
        wait_all_rsp();
        write_reg(CFG_CORE_MASK, 8'h7F);
        n_settings++;
        run_table(4, DIR_ROWS - 1);

        run_setting(8'h01, 8'h01, 20);
        run_setting(8'h0F, 8'hFF, 20);
        overfill_inbox($urandom_range(N_CORES - 1));
        run_setting(8'h00, 8'hFF, 10);

        // writes past the register list must leave both registers alone
        release_req();
        wait_all_rsp();
        write_reg(CFG_SPARE_A, 8'h00);
        write_reg(CFG_SPARE_B, 8'hFF);
        run_setting(8'hF8, 8'hA5, 20);

        repeat (2) begin
            run_setting({4'($urandom_range(15)), 4'($urandom_range(1, N_CORES))},
                        8'($urandom_range(255)), 20);
        end

        release_req();
        wait_all_rsp();
        repeat (60) @(posedge i_clk);

        $display("covered %0d requests, %0d responses, %0d pages drained, %0d full refusals",
                 n_reqs, n_rsps, n_pages, n_full);
        $display("over %0d register settings, %0d mismatches", n_settings, n_errors);
        if (n_errors == 0) begin
            $display("[per_core_remote_free_inbox] OK");
        end else begin
            $display("[per_core_remote_free_inbox] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d responses outstanding", awaited_rsp.size());
        $display("[per_core_remote_free_inbox] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
